[rtl/bc1_bc3_texture_block_decoder_defines.svh]
// ----------------------------------------------------------------------------
// BC1/BC3 block decoder assertion macros
// Shared assertion wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BC1_BC3_TEXTURE_BLOCK_DECODER_DEFINES_SVH
`define BC1_BC3_TEXTURE_BLOCK_DECODER_DEFINES_SVH

// Same-cycle implication.
`define BC13_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bc13 check failed");

// Next-cycle implication.
`define BC13_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bc13 check failed");

`endif

[rtl/bc13_pkg.sv]
// ----------------------------------------------------------------------------
// BC1/BC3 decoder package
// Constants, register indexes and palette arithmetic helpers.
// ----------------------------------------------------------------------------
package bc13_pkg;

    // Image size limits in blocks.
    localparam int MAX_BLOCKS_ACROSS = 1024;
    localparam int COORD_LIMIT_BLOCKS = 1024;
    localparam int WIDTH_LIMIT = (MAX_BLOCKS_ACROSS < COORD_LIMIT_BLOCKS) ?
                                 MAX_BLOCKS_ACROSS : COORD_LIMIT_BLOCKS;

    localparam int CFG_W = 11;
    localparam int CNT_W = 10;
    localparam int IDX_W = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_FORMAT_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH_BLOCKS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT_BLOCKS = 2'd2;

    localparam logic FMT_BC1 = 1'b0;
    localparam logic FMT_BC3 = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef logic [7:0] chan_t;

    // Expand RGB565 to 8-bit channels by bit replication, packed {r, g, b}.
    function automatic logic [23:0] expand565(input logic [15:0] c);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        r5 = c[15:11];
        g6 = c[10:5];
        b5 = c[4:0];
        return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
    endfunction

    // Truncating division by three, exact for x below 8192.
    function automatic chan_t div3(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2731;
        return chan_t'(p >> 13);
    endfunction

    // Truncating division by five, exact for x below 2730.
    function automatic chan_t div5(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd1639;
        return chan_t'(p >> 13);
    endfunction

    // Truncating division by seven, exact for x below 5462.
    function automatic chan_t div7(input logic [10:0] x);
        logic [22:0] p;
        p = 23'(x) * 23'd2341;
        return chan_t'(p >> 14);
    endfunction

    // Clamp a configured size in blocks to the range one to lim.
    function automatic logic [CFG_W-1:0] clamp_blocks(input logic [CFG_W-1:0] v,
                                                      input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] r;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (v > lim)
        begin
            r = lim;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

[rtl/bc1_bc3_texture_block_decoder.sv]
// ----------------------------------------------------------------------------
// BC1/BC3 texture block decoder
// Decodes one compressed 4x4 block per input transfer into sixteen texels
// in raster order, with image coordinates and last-of-block/image flags.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake          Payload
//  -------  -----------------  ------------------------------------------------
//  in       in_valid/in_stall  alpha_word, color_word
//  out      out_valid/out_st.  red, green, blue, alpha_value, pixel_x, pixel_y,
//                              last_of_block, last_of_image
//  cfg      cfg_write          cfg_index, cfg_data
//
// Each block produces sixteen output transfers, one per cycle while the
// output is not stalled; the texel counter of the working stage steps
// through them. When the decoder holds no block, the first texel passes
// through the input register, the working stage and the output register
// before it is on the outputs. A block waits in the input register while
// the previous one is still emitting, so the next block is ready the cycle
// after the sixteenth texel. Reset clears the counters and valid flags and
// sets the configuration registers to their reset values.

`include "bc1_bc3_texture_block_decoder_defines.svh"

module bc1_bc3_texture_block_decoder
    import bc13_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [63:0]        alpha_word,
    input  logic [63:0]        color_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [7:0]         alpha_value,
    output logic [11:0]        pixel_x,
    output logic [11:0]        pixel_y,
    output logic               last_of_block,
    output logic               last_of_image,
    input  logic               cfg_write,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    // Configuration registers.
    logic             format_mode_reg;
    logic [CFG_W-1:0] width_blocks_reg;
    logic [CFG_W-1:0] height_blocks_reg;

    // Input register.
    logic        hold_valid_reg;
    logic [63:0] hold_alpha_reg;
    logic [63:0] hold_color_reg;

    // Block position counters.
    logic [CNT_W-1:0] block_column_reg;
    logic [CNT_W-1:0] block_row_reg;

    // Working stage: palette and indices of the block being emitted.
    logic             work_valid_reg;
    logic [3:0]       texel_reg;
    logic [23:0]      work_pal_reg [4];
    logic [7:0]       work_alpha_reg [8];
    logic [31:0]      work_cidx_reg;
    logic [47:0]      work_aidx_reg;
    logic             work_fmt_reg;
    logic [CNT_W-1:0] work_col_reg;
    logic [CNT_W-1:0] work_row_reg;
    logic             work_last_img_reg;

    // Output register.
    logic        out_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic [11:0] pixel_x_reg;
    logic [11:0] pixel_y_reg;
    logic        last_blk_reg;
    logic        last_img_reg;

    logic out_ready;
    logic emit;
    logic block_end;
    logic load;

    // Handshake control.
    assign out_ready = !out_valid_reg || !out_stall;
    assign emit      = work_valid_reg && out_ready;
    assign block_end = emit && (texel_reg == 4'd15);
    assign load      = hold_valid_reg && (!work_valid_reg || block_end);
    assign in_stall  = hold_valid_reg && !load;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_mode_reg   <= FMT_BC1;
            width_blocks_reg  <= CFG_W'(1);
            height_blocks_reg <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FORMAT_MODE:   format_mode_reg   <= cfg_data[0];
                REG_WIDTH_BLOCKS:  width_blocks_reg  <= cfg_data;
                REG_HEIGHT_BLOCKS: height_blocks_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            hold_alpha_reg <= alpha_word;
            hold_color_reg <= color_word;
        end
    end

    // Block position for the block in the input register.
    logic [CFG_W-1:0] w_clamped;
    logic [CFG_W-1:0] h_clamped;
    logic [CFG_W-1:0] w_last;
    logic [CFG_W-1:0] h_last;
    logic             last_col;
    logic             last_row;
    logic [CNT_W-1:0] col_eff;
    logic [CNT_W-1:0] row_eff;
    logic [CNT_W-1:0] block_column_next;
    logic [CNT_W-1:0] block_row_next;

    always_comb
    begin
        w_clamped = clamp_blocks(width_blocks_reg, CFG_W'(WIDTH_LIMIT));
        h_clamped = clamp_blocks(height_blocks_reg, CFG_W'(COORD_LIMIT_BLOCKS));
        w_last    = w_clamped - CFG_W'(1);
        h_last    = h_clamped - CFG_W'(1);
        last_col  = CFG_W'(block_column_reg) >= w_last;
        last_row  = CFG_W'(block_row_reg) >= h_last;
        col_eff   = last_col ? w_last[CNT_W-1:0] : block_column_reg;
        row_eff   = last_row ? h_last[CNT_W-1:0] : block_row_reg;
        if (last_col)
        begin
            block_column_next = '0;
            block_row_next    = last_row ? '0 : row_eff + CNT_W'(1);
        end
        else
        begin
            block_column_next = col_eff + CNT_W'(1);
            block_row_next    = row_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_column_reg <= '0;
            block_row_reg    <= '0;
        end
        else if (load)
        begin
            block_column_reg <= block_column_next;
            block_row_reg    <= block_row_next;
        end
    end

    // Colour palette from the two RGB565 endpoints.
    logic [15:0] c0_word;
    logic [15:0] c1_word;
    logic [23:0] pal_next [4];
    chan_t       ch0 [3];
    chan_t       ch1 [3];
    chan_t       ch2 [3];
    chan_t       ch3 [3];
    logic [8:0]  ch_sum;

    always_comb
    begin
        c0_word = hold_color_reg[15:0];
        c1_word = hold_color_reg[31:16];
        pal_next[0] = expand565(c0_word);
        pal_next[1] = expand565(c1_word);
        for (int c = 0; c < 3; c++)
        begin
            ch0[c] = pal_next[0][8*c +: 8];
            ch1[c] = pal_next[1][8*c +: 8];
            ch_sum = {1'b0, ch0[c]} + {1'b0, ch1[c]};
            if (c0_word > c1_word)
            begin
                ch2[c] = div3({2'b00, ch0[c], 1'b0}) + div3({3'b000, ch1[c]});
                ch3[c] = div3({3'b000, ch0[c]}) + div3({2'b00, ch1[c], 1'b0});
            end
            else
            begin
                ch2[c] = ch_sum[8:1];
                ch3[c] = '0;
            end
        end
        pal_next[2] = {ch2[2], ch2[1], ch2[0]};
        pal_next[3] = {ch3[2], ch3[1], ch3[0]};
    end

    // Alpha palette from the two 8-bit endpoints.
    chan_t       a0;
    chan_t       a1;
    logic [7:0]  alpha_next [8];

    always_comb
    begin
        a0 = hold_alpha_reg[7:0];
        a1 = hold_alpha_reg[15:8];
        alpha_next[0] = a0;
        alpha_next[1] = a1;
        for (int i = 2; i < 8; i++)
        begin
            if (a0 > a1)
            begin
                alpha_next[i] = div7(11'(a0) * 11'(8 - i)) + div7(11'(a1) * 11'(i - 1));
            end
            else if (i < 6)
            begin
                alpha_next[i] = div5(11'(a0) * 11'(6 - i)) + div5(11'(a1) * 11'(i - 1));
            end
            else if (i == 6)
            begin
                alpha_next[i] = '0;
            end
            else
            begin
                alpha_next[i] = ALPHA_OPAQUE;
            end
        end
    end

    // Working stage control and texel counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            texel_reg      <= '0;
        end
        else if (load)
        begin
            work_valid_reg <= 1'b1;
            texel_reg      <= '0;
        end
        else if (emit)
        begin
            work_valid_reg <= !block_end;
            texel_reg      <= texel_reg + 4'd1;
        end
    end

    // Working stage payload, captured when a block is moved in.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            work_pal_reg      <= pal_next;
            work_alpha_reg    <= alpha_next;
            work_cidx_reg     <= hold_color_reg[63:32];
            work_aidx_reg     <= hold_alpha_reg[63:16];
            work_fmt_reg      <= format_mode_reg;
            work_col_reg      <= col_eff;
            work_row_reg      <= row_eff;
            work_last_img_reg <= last_col && last_row;
        end
    end

    // Texel selection for the current position within the block.
    logic [1:0]  cidx;
    logic [2:0]  aidx;
    logic [23:0] texel_rgb;

    always_comb
    begin
        cidx      = work_cidx_reg[{texel_reg, 1'b0} +: 2];
        aidx      = work_aidx_reg[6'(texel_reg) * 6'd3 +: 3];
        texel_rgb = work_pal_reg[cidx];
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= work_valid_reg;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            red_reg      <= texel_rgb[23:16];
            green_reg    <= texel_rgb[15:8];
            blue_reg     <= texel_rgb[7:0];
            alpha_reg    <= (work_fmt_reg == FMT_BC3) ? work_alpha_reg[aidx] : 8'd0;
            pixel_x_reg  <= {work_col_reg, texel_reg[1:0]};
            pixel_y_reg  <= {work_row_reg, texel_reg[3:2]};
            last_blk_reg <= texel_reg == 4'd15;
            last_img_reg <= (texel_reg == 4'd15) && work_last_img_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red           = red_reg;
    assign green         = green_reg;
    assign blue          = blue_reg;
    assign alpha_value   = alpha_reg;
    assign pixel_x       = pixel_x_reg;
    assign pixel_y       = pixel_y_reg;
    assign last_of_block = last_blk_reg;
    assign last_of_image = last_img_reg;

    // Checks on the texel sequencing.
    `BC13_ASSERT_IMP(a_img_implies_blk, out_valid_reg && last_img_reg, last_blk_reg)
    `BC13_ASSERT_NXT(a_end_gives_last, block_end, out_valid_reg && last_blk_reg)
    `BC13_ASSERT_NXT(a_load_starts, load, work_valid_reg && (texel_reg == 4'd0))

endmodule
